// ----- hdl/gravity_pair_force_core_macros.svh -----
// Assertion helpers for the gravity pair force core
`ifndef GRAVITY_PAIR_FORCE_CORE_MACROS_SVH
`define GRAVITY_PAIR_FORCE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define GPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gpf_pkg.sv -----
package gpf_pkg;

    // G = 6.67384 in Q16.16
    localparam logic [18:0] GRAV_Q16 = 19'd437377;

    localparam int SQ_W       = 66;   // dx^2 + dy^2
    localparam int ROOT_W     = 33;   // floor square root
    localparam int NUM_W      = 116;  // G * m1 * m2 * |d|
    localparam int DEN_W      = 99;   // len^3
    localparam int Q_W        = 48;   // quotient bits kept

    localparam int GPF_SQRT_LAT = ROOT_W;        // one root bit a stage
    localparam int GPF_DIV_LAT  = Q_W + 1;       // range check, then a bit a stage
    localparam int GPF_LAT      = 4 + GPF_SQRT_LAT + 4 + GPF_DIV_LAT + 1;

    localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;

    // per-pair data carried alongside the root pipeline
    typedef struct packed {
        logic [32:0] ax;
        logic [32:0] ay;
        logic [31:0] bm;
        logic        sx;
        logic        sy;
        logic        zero;
        logic        self;
    } side_t;

    // sign and special-case flags carried alongside the dividers
    typedef struct packed {
        logic sx;
        logic sy;
        logic zero;
        logic self;
    } flag_t;

endpackage

// ----- hdl/gpf_sqrt_pipe.sv -----
module gpf_sqrt_pipe (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [gpf_pkg::SQ_W-1:0]     sq,
    output logic [gpf_pkg::ROOT_W-1:0]   root
);
    import gpf_pkg::*;

    localparam int REM_W = ROOT_W + 4;

    logic [REM_W-1:0]  rem_reg  [GPF_SQRT_LAT];
    logic [ROOT_W-1:0] rt_reg   [GPF_SQRT_LAT];
    logic [SQ_W-1:0]   x_reg    [GPF_SQRT_LAT];

    // one root bit per stage, two radicand bits consumed each time
    for (genvar j = 0; j < GPF_SQRT_LAT; j++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] rt_in;
        logic [SQ_W-1:0]   x_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] rt_next;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign rt_in  = '0;
            assign x_in   = sq;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign rt_in  = rt_reg[j-1];
            assign x_in   = x_reg[j-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], x_in[SQ_W-1:SQ_W-2]};
            trial  = REM_W'({rt_in, 2'b01});
            if (rem_sh >= trial) begin
                rem_next = rem_sh - trial;
                rt_next  = {rt_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                rt_next  = {rt_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                rt_reg[j]  <= rt_next;
                x_reg[j]   <= {x_in[SQ_W-3:0], 2'b00};
            end
        end
    end

    assign root = rt_reg[GPF_SQRT_LAT-1];

endmodule

// ----- hdl/gpf_div_pipe.sv -----
module gpf_div_pipe (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [gpf_pkg::NUM_W-1:0]   num,
    input  logic [gpf_pkg::DEN_W-1:0]   den,
    output logic [gpf_pkg::Q_W-1:0]     quot,
    output logic                        ovf
);
    import gpf_pkg::*;

    localparam int R_W  = DEN_W + 1;

    logic [R_W-1:0]   r_reg   [GPF_DIV_LAT];
    logic [Q_W-1:0]   lo_reg  [GPF_DIV_LAT];
    logic [Q_W-1:0]   q_reg   [GPF_DIV_LAT];
    logic [DEN_W-1:0] d_reg   [GPF_DIV_LAT];
    logic             ovf_reg [GPF_DIV_LAT];

    // range check: quotient of 2^48 or more clips anyway
    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= (DEN_W'(num[NUM_W-1:Q_W]) >= den);
            r_reg[0]   <= R_W'(num[NUM_W-1:Q_W]);
            lo_reg[0]  <= num[Q_W-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 1; k < GPF_DIV_LAT; k++) begin : g_step
        logic [R_W-1:0] r_sh;
        logic [R_W-1:0] r_next;
        logic           q_bit;

        always_comb begin
            r_sh = {r_reg[k-1][R_W-2:0], lo_reg[k-1][Q_W-1]};
            if (r_sh >= {1'b0, d_reg[k-1]}) begin
                r_next = r_sh - {1'b0, d_reg[k-1]};
                q_bit  = 1'b1;
            end else begin
                r_next = r_sh;
                q_bit  = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]   <= r_next;
                lo_reg[k]  <= {lo_reg[k-1][Q_W-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][Q_W-2:0], q_bit};
                d_reg[k]   <= d_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quot = q_reg[GPF_DIV_LAT-1];
    assign ovf  = ovf_reg[GPF_DIV_LAT-1];

endmodule

// ----- hdl/gravity_pair_force_core.sv -----
// Gravity pair force core: one planet/body pair per word in, one force vector
// per word out, F = G * planet_mass * body_mass * d / floor(|d|)^3 in Q16.16,
// result Q32.16 saturated to 48 bits; a clipped component sets m_saturated.
// A new pair is taken every cycle while the output is not stalled; each pair
// passes the 33-stage square root chain and the 48-step divider chains behind
// it. The whole pipeline advances together and halts only while a finished
// result waits on m_ready. planet_mass resets to 1.0; the user is to write it
// through cfg_wr_en/cfg_wr_data between pairs, not enforced by the block.
// Self pairs give zero force; coincident non-self pairs set m_coincident too.
`include "gravity_pair_force_core_macros.svh"

module gravity_pair_force_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_planet_x,
    input  logic signed [31:0] s_planet_y,
    input  logic signed [31:0] s_body_x,
    input  logic signed [31:0] s_body_y,
    input  logic [31:0]        s_body_mass,
    input  logic               s_is_self,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_force_x,
    output logic signed [47:0] m_force_y,
    output logic               m_coincident,
    output logic               m_saturated
);
    import gpf_pkg::*;

    logic adv;

    // configuration and the G * planet_mass product
    logic [31:0] planet_mass_reg;
    logic [50:0] pmg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planet_mass_reg <= 32'd65536;
        end else if (cfg_wr_en) begin
            planet_mass_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        pmg_reg <= 51'(planet_mass_reg) * 51'(GRAV_Q16);
    end

    // valid bits travel with the data
    logic vld_reg [GPF_LAT];

    assign adv     = !vld_reg[GPF_LAT-1] || m_ready;
    assign s_ready = aresetn && adv;
    assign m_valid = vld_reg[GPF_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GPF_LAT; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < GPF_LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 0: differences
    logic [32:0] dx0_reg, dy0_reg;
    logic [31:0] bm0_reg;
    logic        self0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx0_reg   <= {s_planet_x[31], s_planet_x} - {s_body_x[31], s_body_x};
            dy0_reg   <= {s_planet_y[31], s_planet_y} - {s_body_y[31], s_body_y};
            bm0_reg   <= s_body_mass;
            self0_reg <= s_is_self;
        end
    end

    // stage 1: magnitudes and signs
    side_t side1_reg, side2_reg, side3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg.sx   <= dx0_reg[32];
            side1_reg.sy   <= dy0_reg[32];
            side1_reg.ax   <= dx0_reg[32] ? (~dx0_reg + 33'd1) : dx0_reg;
            side1_reg.ay   <= dy0_reg[32] ? (~dy0_reg + 33'd1) : dy0_reg;
            side1_reg.zero <= (dx0_reg == '0) && (dy0_reg == '0);
            side1_reg.self <= self0_reg;
            side1_reg.bm   <= bm0_reg;
        end
    end

    // stage 2: squares; stage 3: squared distance
    logic [SQ_W-1:0] sqx2_reg, sqy2_reg, sq3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx2_reg  <= SQ_W'(side1_reg.ax) * SQ_W'(side1_reg.ax);
            sqy2_reg  <= SQ_W'(side1_reg.ay) * SQ_W'(side1_reg.ay);
            side2_reg <= side1_reg;
            sq3_reg   <= sqx2_reg + sqy2_reg;
            side3_reg <= side2_reg;
        end
    end

    // distance: pipelined integer square root
    logic [ROOT_W-1:0] root;
    side_t             side_dly_reg [GPF_SQRT_LAT];

    gpf_sqrt_pipe u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .sq   (sq3_reg),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_dly_reg[0] <= side3_reg;
            for (int i = 1; i < GPF_SQRT_LAT; i++) side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // A1: len^2 and mass product partials
    side_t             sa1_reg, sa2_reg, sa3_reg;
    logic [ROOT_W-1:0] len1_reg;
    logic [65:0]       len2_reg;
    logic [63:0]       kp0_reg;
    logic [50:0]       kp1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            len1_reg <= root;
            len2_reg <= 66'(root) * 66'(root);
            kp0_reg  <= 64'(pmg_reg[31:0]) * 64'(side_dly_reg[GPF_SQRT_LAT-1].bm);
            kp1_reg  <= 51'(pmg_reg[50:32]) * 51'(side_dly_reg[GPF_SQRT_LAT-1].bm);
            sa1_reg  <= side_dly_reg[GPF_SQRT_LAT-1];
        end
    end

    // A2: len^3 partials and the full mass product
    logic [64:0] l3p0_reg;
    logic [66:0] l3p1_reg;
    logic [82:0] k2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            l3p0_reg  <= 65'(len2_reg[31:0]) * 65'(len1_reg);
            l3p1_reg  <= 67'(len2_reg[65:32]) * 67'(len1_reg);
            k2_reg    <= 83'(kp0_reg) + (83'(kp1_reg) << 32);
            sa2_reg   <= sa1_reg;
        end
    end

    // A3: len^3 and numerator partials
    logic [DEN_W-1:0] den3_reg, den4_reg;
    logic [64:0]      bx0_reg, bx1_reg, by0_reg, by1_reg;
    logic [51:0]      bx2_reg, by2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            den3_reg <= DEN_W'(l3p0_reg) + (DEN_W'(l3p1_reg) << 32);
            bx0_reg  <= 65'(k2_reg[31:0]) * 65'(sa2_reg.ax);
            bx1_reg  <= 65'(k2_reg[63:32]) * 65'(sa2_reg.ax);
            bx2_reg  <= 52'(k2_reg[82:64]) * 52'(sa2_reg.ax);
            by0_reg  <= 65'(k2_reg[31:0]) * 65'(sa2_reg.ay);
            by1_reg  <= 65'(k2_reg[63:32]) * 65'(sa2_reg.ay);
            by2_reg  <= 52'(k2_reg[82:64]) * 52'(sa2_reg.ay);
            sa3_reg  <= sa2_reg;
        end
    end

    // A4: numerators
    logic [NUM_W-1:0] numx4_reg, numy4_reg;
    flag_t            flg4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            numx4_reg     <= NUM_W'(bx0_reg) + (NUM_W'(bx1_reg) << 32)
                             + (NUM_W'(bx2_reg) << 64);
            numy4_reg     <= NUM_W'(by0_reg) + (NUM_W'(by1_reg) << 32)
                             + (NUM_W'(by2_reg) << 64);
            den4_reg      <= den3_reg;
            flg4_reg.sx   <= sa3_reg.sx;
            flg4_reg.sy   <= sa3_reg.sy;
            flg4_reg.zero <= sa3_reg.zero;
            flg4_reg.self <= sa3_reg.self;
        end
    end

    // component dividers
    logic [Q_W-1:0] qx, qy;
    logic           ovfx, ovfy;
    flag_t          flg_dly_reg [GPF_DIV_LAT];

    gpf_div_pipe u_div_x (
        .aclk (aclk),
        .en   (adv),
        .num  (numx4_reg),
        .den  (den4_reg),
        .quot (qx),
        .ovf  (ovfx)
    );

    gpf_div_pipe u_div_y (
        .aclk (aclk),
        .en   (adv),
        .num  (numy4_reg),
        .den  (den4_reg),
        .quot (qy),
        .ovf  (ovfy)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            flg_dly_reg[0] <= flg4_reg;
            for (int i = 1; i < GPF_DIV_LAT; i++) flg_dly_reg[i] <= flg_dly_reg[i-1];
        end
    end

    // clip, sign and special cases into the output register
    function automatic logic [48:0] clip_sign(input logic [Q_W-1:0] q,
                                              input logic ovf, input logic neg);
        logic [47:0] lim;
        logic [47:0] mag;
        logic        sat;
        lim = neg ? NEG_LIM : POS_LIM;
        sat = ovf || (q > lim);
        mag = sat ? lim : q;
        return {sat, neg ? (48'd0 - mag) : mag};
    endfunction

    flag_t       flg_out;
    logic [48:0] cx, cy;
    logic [47:0] fx_next, fy_next;
    logic        coin_next, sat_next;

    assign flg_out = flg_dly_reg[GPF_DIV_LAT-1];

    always_comb begin
        cx = clip_sign(qx, ovfx, flg_out.sx);
        cy = clip_sign(qy, ovfy, flg_out.sy);
        if (flg_out.self || flg_out.zero) begin
            fx_next   = '0;
            fy_next   = '0;
            sat_next  = 1'b0;
            coin_next = !flg_out.self;
        end else begin
            fx_next   = cx[47:0];
            fy_next   = cy[47:0];
            sat_next  = cx[48] || cy[48];
            coin_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_force_x    <= fx_next;
            m_force_y    <= fy_next;
            m_coincident <= coin_next;
            m_saturated  <= sat_next;
        end
    end

    // checks
    `GPF_ASSERT_NOW(a_coin_zero, m_valid && m_coincident, (m_force_x == '0) && (m_force_y == '0) && !m_saturated, "coincident word with nonzero force")
    `GPF_ASSERT_NOW(a_sat_at_lim, m_valid && m_saturated, (m_force_x == POS_LIM) || (m_force_x == NEG_LIM) || (m_force_y == POS_LIM) || (m_force_y == NEG_LIM), "saturated word without a clipped component")
    `GPF_ASSERT_NOW(a_ready_free, !m_valid, s_ready, "input stalled with empty output")
    `GPF_ASSERT_NEXT(a_hold_stall, m_valid && !m_ready, m_valid && $stable(m_force_x) && $stable(m_saturated), "output word lost during stall")

endmodule

// ----- tb/sv/tb_gravity_pair_force_core.sv -----
module tb_gravity_pair_force_core;
    import gpf_pkg::*;

    localparam logic [18:0] G_Q16    = 19'd437377;
    localparam int          LIMIT    = 400000;
    localparam int          N_RANDOM = 1500;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [31:0]        bm;
        logic               self_pair;
    } pair_t;

    typedef struct packed {
        logic signed [47:0] fx;
        logic signed [47:0] fy;
        logic               coinc;
        logic               sat;
    } force_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    pair_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [47:0] m_force_x, m_force_y;
    logic m_coincident, m_saturated;

    gravity_pair_force_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_planet_x(s_word.px), .s_planet_y(s_word.py),
        .s_body_x(s_word.bx), .s_body_y(s_word.by),
        .s_body_mass(s_word.bm), .s_is_self(s_word.self_pair),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_force_x(m_force_x), .m_force_y(m_force_y),
        .m_coincident(m_coincident), .m_saturated(m_saturated)
    );

    pair_t  pending_pairs[$];
    force_t expected_forces[$];
    logic [31:0] mass_reg = 32'd65536;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int forces_seen = 0;
    int cycle_count = 0;
    int n_coinc = 0, n_sat = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // one signed component: magnitude truncated, then clipped to 48 bits
    function automatic logic [47:0] force_component(logic [127:0] num, logic [127:0] den,
                                                    logic neg, inout logic sat);
        logic [127:0] mag;
        mag = num / den;
        if (!neg && mag > 128'(POS_LIM)) begin
            sat = 1'b1;
            mag = 128'(POS_LIM);
        end else if (neg && mag > 128'(NEG_LIM)) begin
            sat = 1'b1;
            mag = 128'(NEG_LIM);
        end
        return neg ? 48'(-mag) : mag[47:0];
    endfunction

    function automatic force_t pair_force(pair_t p, logic [31:0] pm);
        force_t r;
        logic signed [33:0] dx, dy;
        logic [33:0] ax, ay;
        logic [127:0] sq, root, cand, den, mm;
        r = '0;
        dx = 34'(p.px) - 34'(p.bx);
        dy = 34'(p.py) - 34'(p.by);
        if (p.self_pair) return r;
        if (dx == 0 && dy == 0) begin
            r.coinc = 1'b1;
            return r;
        end
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        root = 0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (128'(1) << b);
            if (cand * cand <= sq) root = cand;
        end
        den = root * root * root;
        mm = 128'(pm) * 128'(p.bm) * 128'(G_Q16);
        r.fx = force_component(mm * 128'(ax), den, dx < 0, r.sat);
        r.fy = force_component(mm * 128'(ay), den, dy < 0, r.sat);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            3: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        p.px = rand_coord();
        p.py = rand_coord();
        case ($urandom_range(0, 9))
            0: begin p.bx = p.px; p.by = p.py; end
            1: begin p.bx = p.px + $signed($urandom_range(0, 4)) - 2; p.by = p.py; end
            2: begin p.bx = p.px; p.by = p.py + $signed($urandom_range(0, 40)) - 20; end
            3, 4: begin
                p.bx = p.px + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                p.by = p.py + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            end
            default: begin p.bx = rand_coord(); p.by = rand_coord(); end
        endcase
        case ($urandom_range(0, 4))
            0: p.bm = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'h0;
            1: p.bm = $urandom_range(0, 1 << 17);
            default: p.bm = $urandom;
        endcase
        p.self_pair = $urandom_range(0, 15) == 0;
        return p;
    endfunction

    // driver: offers the next pending pair, holding it until taken
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_forces.push_back(pair_force(s_word, mass_reg));
                void'(pending_pairs.pop_front());
            end
            if (!(s_valid && !s_ready)) begin
                if (pending_pairs.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    s_word  <= pending_pairs[0];
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // monitor: every accepted force word against the oldest expectation
    always @(posedge aclk) begin
        force_t exp_f;
        if (aresetn && m_valid && m_ready) begin
            forces_seen <= forces_seen + 1;
            if (expected_forces.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected force word %h %h", m_force_x, m_force_y);
            end else begin
                exp_f = expected_forces.pop_front();
                if (exp_f.coinc) n_coinc <= n_coinc + 1;
                if (exp_f.sat) n_sat <= n_sat + 1;
                if (exp_f.fx !== m_force_x || exp_f.fy !== m_force_y ||
                    exp_f.coinc !== m_coincident || exp_f.sat !== m_saturated) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("force mismatch: exp %h %h c%b s%b got %h %h c%b s%b",
                                 exp_f.fx, exp_f.fy, exp_f.coinc, exp_f.sat,
                                 m_force_x, m_force_y, m_coincident, m_saturated);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycle_count > LIMIT) begin
            $display("timeout with %0d force words outstanding", expected_forces.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic drain();
        while (pending_pairs.size() != 0 || s_valid || expected_forces.size() != 0)
            @(posedge aclk);
        repeat (GPF_LAT + 10) @(posedge aclk);
    endtask

    task automatic set_mass(logic [31:0] m);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        mass_reg    <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic add_pair(logic [31:0] px, logic [31:0] py, logic [31:0] bx,
                            logic [31:0] by, logic [31:0] bm, logic slf);
        pair_t p;
        p.px = px; p.py = py; p.bx = bx; p.by = by; p.bm = bm; p.self_pair = slf;
        pending_pairs.push_back(p);
    endtask

    initial begin
        logic [31:0] masses[5];
        masses = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0003_2000};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset mass, then extremes and the special cases
        add_pair(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 1'b0);
        add_pair(0, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
        add_pair(32'h0012_3400, 32'h0045_6700, 32'h0012_3400, 32'h0045_6700, 32'hFFFF_FFFF,
                 1'b0);
        add_pair(5, 7, 5, 7, 32'hFFFF_FFFF, 1'b1);
        add_pair(5, 7, 100, -3, 32'hFFFF_FFFF, 1'b1);
        add_pair(0, 0, 1, 0, 32'hFFFF_FFFF, 1'b0);
        add_pair(0, 0, 0, -1, 32'hFFFF_FFFF, 1'b0);
        add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                 1'b0);
        add_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 1'b0);
        add_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0);
        add_pair(0, 0, 3, 4, 0, 1'b0);
        add_pair(-2, 3, 2, -3, 32'h0010_0000, 1'b0);
        drain();

        // random phases across mass settings and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            set_mass(ph == 7 ? $urandom : masses[ph % 5]);
            send_idle_pct  = (ph % 4 == 1) ? 50 : (ph % 4 == 3) ? 17 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 50 : (ph % 4 == 3) ? 17 : 0;
            for (int i = 0; i < N_RANDOM / 8; i++) pending_pairs.push_back(rand_pair());
            drain();
        end

        $display("%0d force words checked, %0d coincident, %0d saturated, 6 mass settings",
                 forces_seen, n_coinc, n_sat);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/gpf_pkg.sv
hdl/gpf_sqrt_pipe.sv
hdl/gpf_div_pipe.sv
hdl/gravity_pair_force_core.sv
tb/sv/tb_gravity_pair_force_core.sv
